### rtl/core/wpc_pkg.sv
// ----------------------------------------------------------------------------
// wpc_pkg
// Shared types and constants for the window pattern counter.
// ----------------------------------------------------------------------------
package wpc_pkg;

  localparam int unsigned WindowLen    = 2;
  localparam int unsigned TableEntries = 16;
  localparam int unsigned CountBits    = 16;

  localparam int unsigned ValueW = 32;
  localparam int unsigned EntryW = 4;
  localparam int unsigned ElemW  = 1;
  localparam int unsigned FillW  = $clog2(WindowLen + 1);

  localparam logic OpPush = 1'b0;
  localparam logic OpRead = 1'b1;

  typedef logic [WindowLen-1:0][ValueW-1:0] wpc_window_t;

  typedef struct packed {
    logic                     operation;
    logic signed [ValueW-1:0] value;
    logic [EntryW-1:0]        entry_index;
    logic [ElemW-1:0]         element_index;
  } wpc_in_t;

  typedef struct packed {
    logic                     window_ready;
    logic                     hit;
    logic [EntryW-1:0]        entry;
    logic [CountBits-1:0]     count;
    logic signed [ValueW-1:0] element_value;
    logic                     entry_valid;
  } wpc_out_t;

  // Lookup or read request travelling down the row of cells.
  typedef struct packed {
    logic                 active;
    logic                 operation;
    wpc_window_t          words;
    logic [EntryW-1:0]    entry_index;
    logic [ElemW-1:0]     element_index;
    logic                 found;
    logic [EntryW-1:0]    found_entry;
    logic [CountBits-1:0] count;
    logic [ValueW-1:0]    element_value;
    logic                 entry_valid;
  } wpc_token_t;

  // Insert broadcast to all cells.
  typedef struct packed {
    logic              en;
    logic [EntryW-1:0] entry;
    wpc_window_t       words;
  } wpc_wr_t;

  typedef enum logic [1:0] {
    StIdle,
    StSearch,
    StInsert,
    StDone
  } wpc_state_e;

endpackage

### rtl/core/wpc_cell.sv
// ----------------------------------------------------------------------------
// wpc_cell
// One table entry: stored window, valid bit and count; compares and answers
// the request passing through, then registers it and hands it on.
// ----------------------------------------------------------------------------
module wpc_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [wpc_pkg::EntryW-1:0] cell_id_i,
  input  wpc_pkg::wpc_token_t        tok_i,
  input  wpc_pkg::wpc_wr_t           wr_i,
  output wpc_pkg::wpc_token_t        tok_o
);
  import wpc_pkg::*;

  wpc_window_t          words_q;
  logic                 valid_q;
  logic [CountBits-1:0] count_q, count_d;
  wpc_token_t           tok_q, tok_d;
  logic                 match;
  logic                 sel_read;
  logic                 wr_here;
  logic [ValueW-1:0]    elem;

  assign match    = tok_i.active && (tok_i.operation == OpPush) && valid_q &&
                    !tok_i.found && (words_q == tok_i.words);
  assign sel_read = tok_i.active && (tok_i.operation == OpRead) &&
                    (tok_i.entry_index == cell_id_i);
  assign wr_here  = wr_i.en && (wr_i.entry == cell_id_i);

  always_comb begin
    elem = '0;
    for (int k = 0; k < WindowLen; k++) begin
      if (tok_i.element_index == ElemW'(k)) begin
        elem = words_q[k];
      end
    end
  end

  always_comb begin
    count_d = count_q;
    tok_d   = tok_i;
    if (wr_here) begin
      count_d = CountBits'(1);
    end else if (match) begin
      if (count_q != {CountBits{1'b1}}) begin
        count_d = count_q + CountBits'(1);
      end
      tok_d.found       = 1'b1;
      tok_d.found_entry = cell_id_i;
      tok_d.count       = count_d;
    end
    if (sel_read && valid_q) begin
      tok_d.count         = count_q;
      tok_d.element_value = elem;
      tok_d.entry_valid   = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      count_q <= '0;
      tok_q   <= '0;
    end else begin
      count_q <= count_d;
      tok_q   <= tok_d;
      if (wr_here) begin
        valid_q <= 1'b1;
      end
    end
  end

  // Stored window has no reset; valid_q guards it.
  always_ff @(posedge clk_i) begin
    if (wr_here) begin
      words_q <= wr_i.words;
    end
  end

  assign tok_o = tok_q;

endmodule

### rtl/core/window_pattern_counter_unit.sv
// ----------------------------------------------------------------------------
// window_pattern_counter_unit
// Sliding-window pattern counter built as a row of table-entry cells.
// ----------------------------------------------------------------------------
// Numbers pushed in build a sliding window of WindowLen values; once the
// window is full, every push looks the window up in a table of TableEntries
// cells. A hit bumps that entry's count (saturating at all ones); a miss
// writes the window at a round-robin insert pointer with count 1. A read
// returns one element, the count and the valid flag of an addressed entry.
// Rate: one item at a time. A push that does not yet fill the window goes
// straight to the done state with an empty result. Lookups and reads enter
// the row of cells at cell 0 and pass through a register in each cell; on a
// miss an insert state then writes the window into the table. The table
// starts empty after reset; no clearing pass is needed.
module window_pattern_counter_unit (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  wpc_pkg::wpc_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output wpc_pkg::wpc_out_t out_data_o
);
  import wpc_pkg::*;

  // Control state
  wpc_state_e        state_q, state_d;
  logic [FillW-1:0]  fill_q, fill_d;
  logic [EntryW-1:0] ins_ptr_q, ins_ptr_d;
  logic              out_valid_q, out_valid_d;

  // Datapath registers
  wpc_window_t win_q, win_d;
  wpc_token_t  launch_q, launch_d;
  wpc_out_t    res_q, res_d;
  wpc_out_t    out_q, out_d;

  wpc_token_t  chain [TableEntries+1];
  wpc_token_t  tail;
  wpc_wr_t     wr;
  wpc_window_t win_shift;
  logic        accept;
  logic        out_load;

  assign accept     = in_valid_i && (state_q == StIdle);
  assign in_stall_o = (state_q != StIdle);

  // Window held as a shift line: oldest value at index 0.
  always_comb begin
    for (int k = 0; k < WindowLen - 1; k++) begin
      win_shift[k] = win_q[k+1];
    end
    win_shift[WindowLen-1] = in_data_i.value;
  end

  // ---------------------------------------------------------------------------
  // Row of cells: request enters at cell 0, leaves at the tail
  // ---------------------------------------------------------------------------
  assign chain[0] = launch_q;
  assign tail     = chain[TableEntries];

  for (genvar i = 0; i < TableEntries; i++) begin : g_cell
    wpc_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cell_id_i (EntryW'(i)),
      .tok_i     (chain[i]),
      .wr_i      (wr),
      .tok_o     (chain[i+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    ins_ptr_d   = ins_ptr_q;
    win_d       = win_q;
    res_d       = res_q;
    launch_d    = '0;
    wr          = '0;
    wr.words    = win_q;
    out_load    = 1'b0;
    out_d       = out_q;
    out_valid_d = out_valid_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (accept) begin
          launch_d.operation     = in_data_i.operation;
          launch_d.entry_index   = in_data_i.entry_index;
          launch_d.element_index = in_data_i.element_index;
          launch_d.words         = win_shift;
          if (in_data_i.operation == OpRead) begin
            launch_d.active = 1'b1;
            state_d         = StSearch;
          end else begin
            win_d = win_shift;
            if (fill_q < FillW'(WindowLen)) begin
              fill_d = fill_q + FillW'(1);
            end
            if (fill_q >= FillW'(WindowLen - 1)) begin
              // Window complete: look it up
              launch_d.active = 1'b1;
              state_d         = StSearch;
            end else begin
              res_d   = '0;
              state_d = StDone;
            end
          end
        end
      end

      StSearch: begin
        if (tail.active) begin
          res_d = '0;
          if (tail.operation == OpRead) begin
            res_d.entry         = tail.entry_index;
            res_d.count         = tail.count;
            res_d.element_value = tail.element_value;
            res_d.entry_valid   = tail.entry_valid;
            state_d             = StDone;
          end else if (tail.found) begin
            res_d.window_ready = 1'b1;
            res_d.hit          = 1'b1;
            res_d.entry        = tail.found_entry;
            res_d.count        = tail.count;
            res_d.entry_valid  = 1'b1;
            state_d            = StDone;
          end else begin
            state_d = StInsert;
          end
        end
      end

      StInsert: begin
        // Miss: replace the oldest entry with the current window
        wr.en              = 1'b1;
        wr.entry           = ins_ptr_q;
        res_d              = '0;
        res_d.window_ready = 1'b1;
        res_d.entry        = ins_ptr_q;
        res_d.count        = CountBits'(1);
        res_d.entry_valid  = 1'b1;
        if (ins_ptr_q == EntryW'(TableEntries - 1)) begin
          ins_ptr_d = '0;
        end else begin
          ins_ptr_d = ins_ptr_q + EntryW'(1);
        end
        state_d = StDone;
      end

      StDone: begin
        // Hand the result to the output register once it is free
        if (!out_valid_q || !out_stall_i) begin
          out_load    = 1'b1;
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      fill_q      <= '0;
      ins_ptr_q   <= '0;
      out_valid_q <= 1'b0;
      launch_q    <= '0;
      win_q       <= '0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      ins_ptr_q   <= ins_ptr_d;
      out_valid_q <= out_valid_d;
      launch_q    <= launch_d;
      win_q       <= win_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
